// ===== rtl/rra_pkg.sv =====
// Shared types, codes and helpers for the TCP receive reassembly unit.
// No dependencies; used by the cells and the top level.
package rra_pkg;

    localparam int OOO_DEPTH_DEF     = 8;
    localparam int INORDER_DEPTH_DEF = 16;

    localparam logic [2:0] ST_IN_ORDER  = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_WIN_CLOSE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_INIT   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_INSERT,
        S_DRAIN,
        S_READ,
        S_DONE
    } rra_state_t;

    typedef enum logic [1:0] {
        OOO_HOLD,
        OOO_LOAD,
        OOO_FROM_PREV,
        OOO_FROM_NEXT
    } ooo_op_t;

    typedef enum logic [1:0] {
        IQ_HOLD,
        IQ_LOAD,
        IQ_FROM_NEXT,
        IQ_SETLEN
    } iq_op_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] len;
        logic        push;
    } ooo_entry_t;

    typedef struct packed {
        logic [15:0] len;
        logic        push;
    } iq_entry_t;

    typedef struct packed {
        logic        dup;
        logic        earlier;
        logic        trim;
        logic [15:0] trim_len;
    } ooo_flags_t;

    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage

// ===== rtl/rra_ooo_cell.sv =====
// One entry of the sorted out-of-order table, with its compare against the key.
// Depends on rra_pkg.
module rra_ooo_cell (
    input  logic                aclk,
    input  rra_pkg::ooo_op_t    op,
    input  rra_pkg::ooo_entry_t new_e,
    input  rra_pkg::ooo_entry_t prev_e,
    input  rra_pkg::ooo_entry_t next_e,
    input  logic [31:0]         key_seq,
    input  logic [15:0]         key_len,
    output rra_pkg::ooo_entry_t q,
    output rra_pkg::ooo_flags_t flags
);
    import rra_pkg::*;

    ooo_entry_t  e_reg;
    logic [31:0] diff;
    logic [31:0] key_end;

    always_ff @(posedge aclk) begin
        unique case (op)
            OOO_HOLD:      e_reg <= e_reg;
            OOO_LOAD:      e_reg <= new_e;
            OOO_FROM_PREV: e_reg <= prev_e;
            OOO_FROM_NEXT: e_reg <= next_e;
            default:       e_reg <= e_reg;
        endcase
    end

    always_comb begin
        diff           = key_seq - e_reg.seq;
        key_end        = key_seq + {16'd0, key_len};
        flags.dup      = (diff == 32'd0) || (diff < {16'd0, e_reg.len});
        flags.earlier  = seq_before(key_seq, e_reg.seq);
        flags.trim     = seq_before(e_reg.seq, key_end);
        flags.trim_len = 16'(e_reg.seq - key_seq);
    end

    assign q = e_reg;

endmodule

// ===== rtl/rra_iq_cell.sv =====
// One entry of the in-order queue: length and push flag, shifts towards the head.
// Depends on rra_pkg.
module rra_iq_cell (
    input  logic               aclk,
    input  rra_pkg::iq_op_t    op,
    input  rra_pkg::iq_entry_t new_e,
    input  rra_pkg::iq_entry_t next_e,
    output rra_pkg::iq_entry_t q
);
    import rra_pkg::*;

    iq_entry_t e_reg;

    always_ff @(posedge aclk) begin
        unique case (op)
            IQ_HOLD:      e_reg <= e_reg;
            IQ_LOAD:      e_reg <= new_e;
            IQ_FROM_NEXT: e_reg <= next_e;
            IQ_SETLEN:    e_reg.len <= new_e.len;
            default:      e_reg <= e_reg;
        endcase
    end

    assign q = e_reg;

endmodule

// ===== rtl/tcp_receive_reassembly_unit.sv =====
// TCP receive reassembly unit: top level with sequencer, cell chains and ports.
// Depends on rra_pkg, rra_ooo_cell and rra_iq_cell.
// Each item gives exactly one result item and items are handled one at a time. After the
// accepting edge, a refused or dropped arrival passes through S_EVAL and S_DONE, an
// out-of-order insert through S_EVAL, S_INSERT and S_DONE, an in-order arrival through
// S_EVAL, S_DRAIN and S_DONE, and a read through S_EVAL, S_READ and S_DONE; the drain and
// read loops handle one chain entry per cycle. The result becomes valid in the same cycle
// as the next item can be accepted. A new item is taken while a result waits; a finished
// result holds the unit until the waiting one has been taken.
module tcp_receive_reassembly_unit #(
    parameter int OOO_DEPTH     = rra_pkg::OOO_DEPTH_DEF,
    parameter int INORDER_DEPTH = rra_pkg::INORDER_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // seq_start[31:0], length[47:32], push_req[48], zeros
    input  logic [0:0]  s_tuser,  // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // ack_seq[31:0], send_ack[32], wake_reader[33], bytes_read[49:34], push_seen[50], zeros
    output logic [55:0] m_tdata,
    output logic [2:0]  m_tuser,  // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rra_pkg::*;

    localparam int OCW = $clog2(OOO_DEPTH + 1);
    localparam int ICW = $clog2(INORDER_DEPTH + 1);

    rra_state_t  state_reg, state_next;
    logic        mode_reg;
    logic [31:0] seq_reg;
    logic [15:0] len_reg;
    logic        push_reg;
    logic [15:0] window_reg;
    logic [31:0] init_reg;
    logic [31:0] next_exp_reg, next_exp_next;
    logic [OCW-1:0] ooo_count_reg, ooo_count_next;
    logic [ICW-1:0] iq_count_reg, iq_count_next;
    logic        sticky_reg, sticky_next;
    logic [15:0] got_reg, got_next;
    logic [2:0]  status_reg, status_next;
    logic        ack_reg, ack_next;
    logic        wake_reg, wake_next;
    logic [OCW-1:0] pos_reg, pos_next;
    logic [15:0] ins_len_reg, ins_len_next;
    logic        m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg;
    logic [2:0]  m_user_reg;

    ooo_op_t    ooo_op   [OOO_DEPTH];
    ooo_entry_t ooo_q    [OOO_DEPTH];
    ooo_flags_t ooo_fl   [OOO_DEPTH];
    ooo_entry_t ooo_new;
    iq_op_t     iq_op    [INORDER_DEPTH];
    iq_entry_t  iq_q     [INORDER_DEPTH];
    iq_entry_t  iq_new;

    logic        cfg_wr;
    logic        hit_found, hit_dup, hit_trim;
    logic [OCW-1:0] hit_pos;
    logic [15:0] hit_trim_len;
    logic [15:0] remain, take, head_left;
    logic        out_free;

    genvar g;
    generate
        for (g = 0; g < OOO_DEPTH; g++) begin : g_ooo
            rra_ooo_cell u_cell (
                .aclk    (aclk),
                .op      (ooo_op[g]),
                .new_e   (ooo_new),
                .prev_e  ((g == 0) ? ooo_new : ooo_q[(g == 0) ? 0 : g - 1]),
                .next_e  ((g == OOO_DEPTH - 1) ? ooo_q[g] :
                          ooo_q[(g == OOO_DEPTH - 1) ? g : g + 1]),
                .key_seq (seq_reg),
                .key_len (len_reg),
                .q       (ooo_q[g]),
                .flags   (ooo_fl[g])
            );
        end
        for (g = 0; g < INORDER_DEPTH; g++) begin : g_iq
            rra_iq_cell u_cell (
                .aclk   (aclk),
                .op     (iq_op[g]),
                .new_e  (iq_new),
                .next_e ((g == INORDER_DEPTH - 1) ? iq_q[g] :
                         iq_q[(g == INORDER_DEPTH - 1) ? g : g + 1]),
                .q      (iq_q[g])
            );
        end
    endgenerate

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_INIT) ? init_reg : {16'd0, window_reg};
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign out_free = !m_valid_reg || m_tready;

    // first held entry that the key falls into or lies before
    always_comb begin
        hit_found    = 1'b0;
        hit_dup      = 1'b0;
        hit_trim     = 1'b0;
        hit_trim_len = 16'd0;
        hit_pos      = ooo_count_reg;
        for (int i = OOO_DEPTH - 1; i >= 0; i--) begin
            if ((OCW'(i) < ooo_count_reg) && (ooo_fl[i].dup || ooo_fl[i].earlier)) begin
                hit_found    = 1'b1;
                hit_dup      = ooo_fl[i].dup;
                hit_trim     = ooo_fl[i].trim;
                hit_trim_len = ooo_fl[i].trim_len;
                hit_pos      = OCW'(i);
            end
        end
    end

    always_comb begin
        remain    = len_reg - got_reg;
        take      = (iq_q[0].len > remain) ? remain : iq_q[0].len;
        head_left = iq_q[0].len - take;
    end

    always_comb begin
        state_next     = state_reg;
        next_exp_next  = next_exp_reg;
        ooo_count_next = ooo_count_reg;
        iq_count_next  = iq_count_reg;
        sticky_next    = sticky_reg;
        got_next       = got_reg;
        status_next    = status_reg;
        ack_next       = ack_reg;
        wake_next      = wake_reg;
        pos_next       = pos_reg;
        ins_len_next   = ins_len_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        ooo_new        = '{seq: seq_reg, len: ins_len_reg, push: push_reg};
        iq_new         = '{len: len_reg, push: push_reg};
        for (int i = 0; i < OOO_DEPTH; i++) ooo_op[i] = OOO_HOLD;
        for (int i = 0; i < INORDER_DEPTH; i++) iq_op[i] = IQ_HOLD;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EVAL;
            end
            S_EVAL: begin
                status_next = ST_IN_ORDER;
                ack_next    = 1'b0;
                wake_next   = 1'b0;
                got_next    = 16'd0;
                state_next  = S_DONE;
                if (mode_reg) begin
                    state_next = S_READ;
                end else if (window_reg == 16'd0) begin
                    status_next = ST_WIN_CLOSE;
                end else if (seq_reg == next_exp_reg) begin
                    if (iq_count_reg == ICW'(INORDER_DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        for (int i = 0; i < INORDER_DEPTH; i++)
                            if (ICW'(i) == iq_count_reg) iq_op[i] = IQ_LOAD;
                        iq_count_next = iq_count_reg + 1'b1;
                        next_exp_next = next_exp_reg + {16'd0, len_reg};
                        ack_next      = 1'b1;
                        wake_next     = 1'b1;
                        state_next    = S_DRAIN;
                    end
                end else if (hit_found && hit_dup) begin
                    status_next = ST_DUPLICATE;
                    ack_next    = 1'b1;
                end else if (ooo_count_reg == OCW'(OOO_DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    pos_next     = hit_pos;
                    ins_len_next = (hit_found && hit_trim) ? hit_trim_len : len_reg;
                    status_next  = ST_QUEUED;
                    ack_next     = 1'b1;
                    state_next   = S_INSERT;
                end
            end
            S_INSERT: begin
                for (int i = 0; i < OOO_DEPTH; i++) begin
                    if (OCW'(i) == pos_reg) ooo_op[i] = OOO_LOAD;
                    else if (OCW'(i) > pos_reg) ooo_op[i] = OOO_FROM_PREV;
                end
                ooo_count_next = ooo_count_reg + 1'b1;
                state_next     = S_DONE;
            end
            S_DRAIN: begin
                if (ooo_count_reg != '0 && iq_count_reg != ICW'(INORDER_DEPTH) &&
                    ooo_q[0].seq == next_exp_reg) begin
                    iq_new = '{len: ooo_q[0].len, push: ooo_q[0].push};
                    for (int i = 0; i < INORDER_DEPTH; i++)
                        if (ICW'(i) == iq_count_reg) iq_op[i] = IQ_LOAD;
                    for (int i = 0; i < OOO_DEPTH; i++) ooo_op[i] = OOO_FROM_NEXT;
                    iq_count_next  = iq_count_reg + 1'b1;
                    ooo_count_next = ooo_count_reg - 1'b1;
                    next_exp_next  = next_exp_reg + {16'd0, ooo_q[0].len};
                end else begin
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                if (iq_count_reg != '0 && got_reg < len_reg) begin
                    got_next = got_reg + take;
                    if (head_left == 16'd0) begin
                        if (iq_q[0].push) sticky_next = 1'b1;
                        for (int i = 0; i < INORDER_DEPTH; i++) iq_op[i] = IQ_FROM_NEXT;
                        iq_count_next = iq_count_reg - 1'b1;
                    end else begin
                        iq_new.len = head_left;
                        iq_op[0]   = IQ_SETLEN;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_wr && paddr[2] == REG_INIT) next_exp_next = pwdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            window_reg    <= 16'hFFFF;
            init_reg      <= 32'd0;
            next_exp_reg  <= 32'd0;
            ooo_count_reg <= '0;
            iq_count_reg  <= '0;
            sticky_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_exp_reg  <= next_exp_next;
            ooo_count_reg <= ooo_count_next;
            iq_count_reg  <= iq_count_next;
            sticky_reg    <= sticky_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr && paddr[2] == REG_WINDOW) window_reg <= pwdata[15:0];
            if (cfg_wr && paddr[2] == REG_INIT) init_reg <= pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        got_reg     <= got_next;
        status_reg  <= status_next;
        ack_reg     <= ack_next;
        wake_reg    <= wake_next;
        pos_reg     <= pos_next;
        ins_len_reg <= ins_len_next;
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tuser[0];
            seq_reg  <= s_tdata[31:0];
            len_reg  <= s_tdata[47:32];
            push_reg <= s_tdata[48];
        end
        if (state_reg == S_DONE && out_free) begin
            m_data_reg <= {5'd0, sticky_reg, got_reg, wake_reg, ack_reg, next_exp_reg};
            m_user_reg <= status_reg;
        end
    end

    a_ooo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ooo_count_reg <= OCW'(OOO_DEPTH))
        else $error("out-of-order count beyond depth");
    a_iq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iq_count_reg <= ICW'(INORDER_DEPTH))
        else $error("in-order count beyond depth");
    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_EVAL)
        else $error("accepted item not evaluated");
    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && out_free |=> m_valid_reg)
        else $error("finished result not presented");

endmodule
